// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the command frame parser modules.
// Each macro expects clk_i and rst_ni to exist in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define UCFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen outside of reset.
`define UCFP_ASSERT_NEVER(label, cond, msg) \
  `UCFP_ASSERT(label, !(cond), msg)

`endif

// ----- rtl/ucfp_pkg.sv -----
// Shared types and constants of the command frame parser.
// No dependencies; the parser, command queue, reply sender and core modules import this package.
package ucfp_pkg;

  // Fixed framing constants.
  localparam int unsigned LENGTH_MIN       = 3;
  localparam int unsigned HEADER_BYTES     = 5;
  localparam logic [7:0]  REPLY_TYPE_BYTE  = 8'h02;
  localparam int unsigned OPCODE_MASK_BITS = 64;
  localparam int unsigned OPCODE_IDX_W     = $clog2(OPCODE_MASK_BITS);

  // Command queue between the parser and the reply sender.
  localparam int unsigned CMD_FIFO_DEPTH = 2;
  localparam int unsigned CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
  localparam int unsigned CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_REQUEST_START = 3'd0,
    CFG_REPLY_START   = 3'd1,
    CFG_ACK_CODE      = 3'd2,
    CFG_NAK_CODE      = 3'd3,
    CFG_ACTIVE_APP    = 3'd4,
    CFG_IDENTIFY_OP   = 3'd5,
    CFG_RETURN_HOME   = 3'd6,
    CFG_OPCODE_MASK   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]                  request_start_code;
    logic [7:0]                  reply_start_code;
    logic [7:0]                  ack_code;
    logic [7:0]                  nak_code;
    logic [7:0]                  active_app_id;
    logic [7:0]                  identify_opcode;
    logic [7:0]                  return_home_opcode;
    logic [OPCODE_MASK_BITS-1:0] accepted_opcode_mask;
  } cfg_t;

  // One classified command, waiting for its reply to be sent.
  typedef struct packed {
    logic [7:0] seq_num;
    logic [7:0] app;
    logic [7:0] opcode;
    logic [7:0] status;
    logic       accepted;
  } cmd_t;

  // Channel words.
  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
    logic [7:0] cmd_app;
    logic [7:0] cmd_opcode;
    logic       cmd_accepted;
  } tx_word_t;

endpackage

// ----- rtl/ucfp_stream_if.sv -----
// Valid/ready stream interface used for the byte channels.
// No dependencies; the word type is set by the instantiating scope.
interface ucfp_stream_if #(
  parameter type T = logic [7:0]
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/ucfp_parser.sv -----
// Front end: tracks frame position, captures the header and classifies a
// finished frame into a command record. Depends on ucfp_pkg.
module ucfp_parser
  import ucfp_pkg::*;
#(
  parameter int unsigned FRAME_BYTES_MAX = 64,
  parameter int unsigned PAYLOAD_MAX     = 48,
  parameter int unsigned GLOBAL_APP_ID   = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       rx_valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       rx_ready_o,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_ready_i
);

  localparam int unsigned PosW = $clog2(FRAME_BYTES_MAX + 1);
  localparam logic [PosW-1:0] PosHunt   = PosW'(0);
  localparam logic [PosW-1:0] PosLength = PosW'(1);
  localparam logic [PosW-1:0] PosSeq    = PosW'(2);
  localparam logic [PosW-1:0] PosApp    = PosW'(3);
  localparam logic [PosW-1:0] PosOpcode = PosW'(4);

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] total_q, total_d;
  logic [PosW-1:0] pos_inc;
  logic [7:0]      seq_q, app_q, op_q;
  logic [7:0]      seq_c, app_c, op_c;
  logic [8:0]      len_total;
  logic            accept, len_bad, frame_end;
  logic            is_global, special, pay_ok, frame_good, mask_hit, need_reply;
  logic [7:0]      status;
  logic            accepted;

  // A byte is taken whenever the command queue can absorb a possible command.
  assign rx_ready_o = cmd_ready_i;
  assign accept     = rx_valid_i && cmd_ready_i;

  // Header fields as they stand after this byte.
  assign seq_c = (pos_q == PosSeq) ? rx_byte_i : seq_q;
  assign app_c = (pos_q == PosApp) ? rx_byte_i : app_q;
  assign op_c  = (pos_q == PosOpcode) ? rx_byte_i : op_q;

  // Length check: total frame size is taken without wrap.
  assign len_total = 9'(rx_byte_i) + 9'd2;
  assign len_bad   = (rx_byte_i < 8'(LENGTH_MIN)) || (len_total > 9'(FRAME_BYTES_MAX));
  assign pos_inc   = pos_q + 1'b1;
  assign frame_end = (pos_q >= PosSeq) && (pos_inc == total_q);

  // Position tracking. The stored total never exceeds the frame limit, so the
  // body always ends on the total before the limit is reached.
  always_comb begin
    pos_d   = pos_q;
    total_d = total_q;
    if (accept) begin
      if (pos_q == PosHunt) begin
        if (rx_byte_i == cfg_i.request_start_code) begin
          pos_d = PosLength;
        end
      end else if (pos_q == PosLength) begin
        if (len_bad) begin
          pos_d   = PosHunt;
          total_d = '0;
        end else begin
          pos_d   = PosSeq;
          total_d = PosW'(len_total);
        end
      end else if (frame_end) begin
        pos_d   = PosHunt;
        total_d = '0;
      end else begin
        pos_d = pos_inc;
      end
    end
  end

  // Frame checks and reply classification.
  assign is_global = (app_c == 8'(GLOBAL_APP_ID));
  assign special   = is_global &&
                     ((op_c == cfg_i.identify_opcode) || (op_c == cfg_i.return_home_opcode));
  assign pay_ok    = (9'(total_q) <= 9'(PAYLOAD_MAX + HEADER_BYTES));
  assign frame_good = (seq_c != 8'd0) && pay_ok &&
                      (is_global || (app_c == cfg_i.active_app_id));
  assign mask_hit  = (op_c < 8'(OPCODE_MASK_BITS)) &&
                     cfg_i.accepted_opcode_mask[op_c[OPCODE_IDX_W-1:0]];

  always_comb begin
    need_reply = 1'b1;
    status     = cfg_i.nak_code;
    accepted   = 1'b0;
    if (!frame_good) begin
      status = special ? cfg_i.active_app_id : cfg_i.nak_code;
    end else if (is_global) begin
      // Other global opcodes are silently dropped.
      need_reply = special;
      status     = cfg_i.active_app_id;
      accepted   = 1'b1;
    end else begin
      status   = mask_hit ? cfg_i.ack_code : cfg_i.nak_code;
      accepted = mask_hit;
    end
  end

  assign cmd_valid_o = accept && frame_end && need_reply;
  assign cmd_o = '{seq_num: seq_c, app: app_c, opcode: op_c,
                   status: status, accepted: accepted};

  // Position and length registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosHunt;
      total_q <= '0;
    end else begin
      pos_q   <= pos_d;
      total_q <= total_d;
    end
  end

  // Captured header bytes.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      seq_q <= seq_c;
      app_q <= app_c;
      op_q  <= op_c;
    end
  end

endmodule

// ----- rtl/ucfp_cmd_fifo.sv -----
// Short command queue between the parser and the reply sender.
// Depends on ucfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ucfp_cmd_fifo
  import ucfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_cmd_o,
  input  logic pop_ready_i
);

  localparam logic [CMD_PTR_W-1:0] LastPtr = CMD_PTR_W'(CMD_FIFO_DEPTH - 1);

  cmd_t                 mem_q [CMD_FIFO_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_CNT_W-1:0] count_q;
  logic                 push, pop;

  assign push_ready_o = (count_q != CMD_CNT_W'(CMD_FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `UCFP_ASSERT_NEVER(a_count_bound, count_q > CMD_CNT_W'(CMD_FIFO_DEPTH), "fifo overfilled")
  `UCFP_ASSERT(a_push_grows, push && !pop |=> count_q == $past(count_q) + 1'b1, "push lost")
  `UCFP_ASSERT(a_pop_shrinks, pop && !push |=> count_q == $past(count_q) - 1'b1, "pop lost")

endmodule

// ----- rtl/ucfp_reply_tx.sv -----
// Back end: sends the four-byte reply for each queued command.
// Depends on ucfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ucfp_reply_tx
  import ucfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] reply_start_i,
  input  logic       pop_valid_i,
  input  cmd_t       pop_cmd_i,
  output logic       pop_ready_o,
  output logic       tx_valid_o,
  output tx_word_t   tx_word_o,
  input  logic       tx_ready_i
);

  typedef enum logic [1:0] {
    SLOT_START  = 2'd0,
    SLOT_TYPE   = 2'd1,
    SLOT_SEQ    = 2'd2,
    SLOT_STATUS = 2'd3
  } reply_slot_e;

  reply_slot_e slot_q;
  logic        busy_q;
  cmd_t        rec_q;
  logic        tx_take, last;
  logic [7:0]  tx_byte;

  assign last        = (slot_q == SLOT_STATUS);
  assign tx_take     = busy_q && tx_ready_i;
  // A new command loads when idle or as the final byte of the current one leaves.
  assign pop_ready_o = !busy_q || (tx_ready_i && last);

  // Byte selection for the current slot.
  always_comb begin
    case (slot_q)
      SLOT_START:  tx_byte = reply_start_i;
      SLOT_TYPE:   tx_byte = REPLY_TYPE_BYTE;
      SLOT_SEQ:    tx_byte = rec_q.seq_num;
      SLOT_STATUS: tx_byte = rec_q.status;
      default:     tx_byte = '0;
    endcase
  end

  assign tx_valid_o = busy_q;
  assign tx_word_o  = '{tx_byte: tx_byte, last_byte: last, cmd_app: rec_q.app,
                        cmd_opcode: rec_q.opcode, cmd_accepted: rec_q.accepted};

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= SLOT_START;
    end else if (pop_ready_o && pop_valid_i) begin
      busy_q <= 1'b1;
      slot_q <= SLOT_START;
    end else if (tx_take) begin
      if (last) begin
        busy_q <= 1'b0;
        slot_q <= SLOT_START;
      end else begin
        slot_q <= reply_slot_e'(slot_q + 2'd1);
      end
    end
  end

  // Command record of the reply in flight.
  always_ff @(posedge clk_i) begin
    if (pop_ready_o && pop_valid_i) begin
      rec_q <= pop_cmd_i;
    end
  end

  `UCFP_ASSERT(a_slot_step, tx_take && !last |=> busy_q && (2'(slot_q) == 2'($past(slot_q) + 2'd1)), "slot skipped")
  `UCFP_ASSERT(a_drain_idle, tx_take && last && !pop_valid_i |=> !busy_q, "reply overran")
  `UCFP_ASSERT(a_rec_hold, busy_q && !tx_ready_i |=> busy_q && $stable(rec_q), "record changed")

endmodule

// ----- rtl/uart_command_frame_parser_core.sv -----
// Command frame parser: accepts one received byte per cycle; the parser never stalls
// while the two-entry command queue has room. A frame's last byte queues a command if
// it needs a reply; the reply sender loads it and sends four words, one per cycle
// while the output is ready. A frame is at least five bytes, so input runs at full
// rate with an always-ready output. Reset is asynchronous, active low: it returns
// the parser to hunting, empties the queue and loads register defaults.
module uart_command_frame_parser_core
  import ucfp_pkg::*;
#(
  parameter int unsigned FRAME_BYTES_MAX = 64,
  parameter int unsigned PAYLOAD_MAX     = 48,
  parameter int unsigned GLOBAL_APP_ID   = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  ucfp_stream_if.sink            rx_if_i,
  ucfp_stream_if.source          tx_if_o
);

  cfg_t     cfg_q;
  logic     cmd_valid, cmd_ready;
  cmd_t     cmd;
  logic     q_valid, q_ready;
  cmd_t     q_cmd;
  logic     rx_ready;
  logic     tx_valid;
  tx_word_t tx_word;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.request_start_code   <= 8'd0;
      cfg_q.reply_start_code     <= 8'd0;
      cfg_q.ack_code             <= 8'd0;
      cfg_q.nak_code             <= 8'd0;
      cfg_q.active_app_id        <= 8'd1;
      cfg_q.identify_opcode      <= 8'd0;
      cfg_q.return_home_opcode   <= 8'd1;
      cfg_q.accepted_opcode_mask <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_REQUEST_START: cfg_q.request_start_code   <= cfg_wdata_i[7:0];
        CFG_REPLY_START:   cfg_q.reply_start_code     <= cfg_wdata_i[7:0];
        CFG_ACK_CODE:      cfg_q.ack_code             <= cfg_wdata_i[7:0];
        CFG_NAK_CODE:      cfg_q.nak_code             <= cfg_wdata_i[7:0];
        CFG_ACTIVE_APP:    cfg_q.active_app_id        <= cfg_wdata_i[7:0];
        CFG_IDENTIFY_OP:   cfg_q.identify_opcode      <= cfg_wdata_i[7:0];
        CFG_RETURN_HOME:   cfg_q.return_home_opcode   <= cfg_wdata_i[7:0];
        CFG_OPCODE_MASK:   cfg_q.accepted_opcode_mask <= cfg_wdata_i[OPCODE_MASK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Front end: frame tracking and classification.
  ucfp_parser #(
    .FRAME_BYTES_MAX (FRAME_BYTES_MAX),
    .PAYLOAD_MAX     (PAYLOAD_MAX),
    .GLOBAL_APP_ID   (GLOBAL_APP_ID)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rx_valid_i  (rx_if_i.valid),
    .rx_byte_i   (rx_if_i.payload.rx_byte),
    .rx_ready_o  (rx_ready),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  assign rx_if_i.ready = rx_ready;

  // Command queue.
  ucfp_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_cmd_i   (cmd),
    .push_ready_o (cmd_ready),
    .pop_valid_o  (q_valid),
    .pop_cmd_o    (q_cmd),
    .pop_ready_i  (q_ready)
  );

  // Back end: reply word sequencing.
  ucfp_reply_tx u_reply_tx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .reply_start_i (cfg_q.reply_start_code),
    .pop_valid_i   (q_valid),
    .pop_cmd_i     (q_cmd),
    .pop_ready_o   (q_ready),
    .tx_valid_o    (tx_valid),
    .tx_word_o     (tx_word),
    .tx_ready_i    (tx_if_o.ready)
  );

  assign tx_if_o.valid   = tx_valid;
  assign tx_if_o.payload = tx_word;

endmodule
